@@ sv/ascii_hex_scan_telegram_parser_defines.svh @@
// Assertion macros for the ASCII hex scan telegram parser
`ifndef ASCII_HEX_SCAN_TELEGRAM_PARSER_DEFINES_SVH
`define ASCII_HEX_SCAN_TELEGRAM_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define AHST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AHST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ahst_pkg.sv @@
// Shared types, constants and helpers of the ASCII hex scan telegram parser
package ahst_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 10;
  localparam int DIST_W     = 16;
  localparam int POS_W      = 6;

  localparam logic [POS_W-1:0] CFG_POS_RESET = 6'd25;
  localparam logic [POS_W-1:0] SPACE_SAT     = 6'd63;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ETX   = 8'h03;

  localparam logic RK_POINT    = 1'b0;
  localparam logic RK_SCAN_END = 1'b1;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_COUNT  = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_DONE   = 4'b1000
  } ahst_phase_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
    logic       eob;
  } ahst_item_t;

  typedef struct packed {
    logic              vld;
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } ahst_result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

@@ sv/ascii_hex_scan_telegram_parser.sv @@
// Top level: ASCII hex scan telegram parser
// Takes one telegram byte per cycle unless a result waits on a stalled output, and
// gives at most one result per byte: a distance point when a data field's space
// or NUL terminator arrives, or a scan-end summary on ETX or an end-of-buffer byte,
// which also clears all parse state. A request passes an input register, the
// parse logic and the result register. The point count field position is the
// cfg register (reset 25); the user must write it only when idle, since the
// block itself does not enforce this.
module ascii_hex_scan_telegram_parser
  import ahst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [POS_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_end_of_buffer,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_result_kind,
  output logic [IDX_W-1:0]  out_point_index,
  output logic [DIST_W-1:0] out_distance,
  output logic [CNT_W-1:0]  out_point_count,
  output logic              out_is_last
);

  ahst_item_t       item;
  ahst_result_t     res;
  logic             adv;
  logic [POS_W-1:0] pos_r;
  logic             ovld_r, ovld_nxt;
  ahst_result_t     ores_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= CFG_POS_RESET;
    end else if (cfg_valid) begin
      pos_r <= cfg_data;
    end
  end

  assign adv = item.vld && (!res.vld || !ovld_r || out_ready);

  ahst_in_reg u_in (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .adv              (adv),
    .item             (item)
  );

  ahst_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_pos (pos_r),
    .item    (item),
    .adv     (adv),
    .res     (res)
  );

  assign ovld_nxt = (adv && res.vld) ? 1'b1 : (out_ready ? 1'b0 : ovld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.vld) begin
      ores_r <= res;
    end
  end

  assign out_valid       = ovld_r;
  assign out_result_kind = ores_r.kind;
  assign out_point_index = ores_r.idx;
  assign out_distance    = ores_r.distance;
  assign out_point_count = ores_r.cnt;
  assign out_is_last     = ores_r.last;

endmodule

@@ sv/ahst_in_reg.sv @@
// Input request register of the telegram parser
module ahst_in_reg
  import ahst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_end_of_buffer,
  input  logic       adv,
  output ahst_item_t item
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       eob_r;

  assign in_ready = !vld_r || adv;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
      eob_r  <= in_end_of_buffer;
    end
  end

  assign item = '{vld: vld_r, rx_byte: byte_r, eob: eob_r};

endmodule

@@ sv/ahst_core.sv @@
// Parse state and single-pass step logic of the telegram parser
module ahst_core
  import ahst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [POS_W-1:0] cfg_pos,
  input  ahst_item_t       item,
  input  logic             adv,
  output ahst_result_t     res
);

  logic [POS_W-1:0]  sc_r, sc_nxt;
  ahst_phase_t       ph_r, ph_nxt;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic              stop_r, stop_nxt;
  logic [CNT_W-1:0]  ann_r, ann_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;

  logic [4:0]        hx;
  logic [POS_W-1:0]  sc_inc;
  logic [CNT_W-1:0]  clip;
  logic              is_sp;
  logic              last;

  always_comb begin
    hx     = hex_nibble(item.rx_byte);
    is_sp  = item.rx_byte == CH_SPACE;
    sc_inc = (sc_r == SPACE_SAT) ? sc_r : sc_r + 1'b1;
    clip   = (acc_r > DIST_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : acc_r[CNT_W-1:0];
    last   = ({1'b0, done_r} + 1'b1) >= {1'b0, ann_r};

    sc_nxt   = sc_r;
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    stop_nxt = stop_r;
    ann_nxt  = ann_r;
    done_nxt = done_r;
    res      = '{vld: 1'b0, kind: RK_POINT, idx: '0, distance: '0, cnt: ann_r, last: 1'b0};

    if (item.rx_byte == CH_ETX || item.eob) begin
      res.vld   = 1'b1;
      res.kind  = RK_SCAN_END;
      res.last  = 1'b1;
      sc_nxt    = '0;
      ph_nxt    = PH_SEARCH;
      acc_nxt   = '0;
      stop_nxt  = 1'b0;
      ann_nxt   = '0;
      done_nxt  = '0;
    end else begin
      case (ph_r)
        PH_SEARCH: begin
          if (is_sp) begin
            sc_nxt = sc_inc;
            if (sc_inc == cfg_pos) begin
              ph_nxt   = PH_COUNT;
              acc_nxt  = '0;
              stop_nxt = 1'b0;
            end
          end
        end
        PH_COUNT: begin
          if (is_sp) begin
            ann_nxt  = clip;
            acc_nxt  = '0;
            stop_nxt = 1'b0;
            done_nxt = '0;
            ph_nxt   = (clip == '0) ? PH_DONE : PH_DATA;
          end else if (!stop_r) begin
            if (hx[4]) acc_nxt = {acc_r[DIST_W-5:0], hx[3:0]};
            else       stop_nxt = 1'b1;
          end
        end
        PH_DATA: begin
          if (is_sp || item.rx_byte == CH_NUL) begin
            res.vld      = 1'b1;
            res.idx      = done_r[IDX_W-1:0];
            res.distance = acc_r;
            res.last     = last;
            done_nxt = done_r + 1'b1;
            acc_nxt  = '0;
            stop_nxt = 1'b0;
            if (last) ph_nxt = PH_DONE;
          end else if (!stop_r) begin
            if (hx[4]) acc_nxt = {acc_r[DIST_W-5:0], hx[3:0]};
            else       stop_nxt = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
          ph_nxt = PH_SEARCH;
        end
      endcase
    end
    res.vld = res.vld && item.vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r   <= '0;
      ph_r   <= PH_SEARCH;
      acc_r  <= '0;
      stop_r <= 1'b0;
      ann_r  <= '0;
      done_r <= '0;
    end else if (adv) begin
      sc_r   <= sc_nxt;
      ph_r   <= ph_nxt;
      acc_r  <= acc_nxt;
      stop_r <= stop_nxt;
      ann_r  <= ann_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

@@ sv/ahst_checker.sv @@
// Port-level assertions for the telegram parser, bound to the top level
`include "ascii_hex_scan_telegram_parser_defines.svh"

module ahst_checker
  import ahst_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_result_kind,
  input logic [IDX_W-1:0]  out_point_index,
  input logic [DIST_W-1:0] out_distance,
  input logic [CNT_W-1:0]  out_point_count,
  input logic              out_is_last
);

  `AHST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_distance) && $stable(out_point_index) && $stable(out_result_kind), "stalled result changed")
  `AHST_ASSERT_NOW(a_end_shape, out_valid && out_result_kind == RK_SCAN_END, out_is_last && out_point_index == '0 && out_distance == '0, "bad scan-end result")
  `AHST_ASSERT_NOW(a_pt_range, out_valid && out_result_kind == RK_POINT, out_point_count != '0 && out_point_count <= CNT_W'(MAX_POINTS) && {1'b0, out_point_index} < out_point_count, "point index out of range")
  `AHST_ASSERT_NOW(a_pt_last, out_valid && out_result_kind == RK_POINT, out_is_last == (({1'b0, out_point_index} + 1'b1) == out_point_count), "last mark wrong")
  `AHST_ASSERT_NOW(a_in_free, !out_valid, in_ready, "input stalled with empty result register")

endmodule

bind ascii_hex_scan_telegram_parser ahst_checker u_ahst_checker (.*);

@@ test/scan_result_checker.sv @@
// Checker for the ASCII hex scan telegram parser: predicts each result and compares it
module scan_result_checker
  import ahst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [POS_W-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              in_end_of_buffer,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_result_kind,
  input  logic [IDX_W-1:0]  out_point_index,
  input  logic [DIST_W-1:0] out_distance,
  input  logic [CNT_W-1:0]  out_point_count,
  input  logic              out_is_last,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } scan_rec_t;

  logic [POS_W-1:0]  field_pos;
  logic [POS_W-1:0]  spaces_seen;
  ahst_phase_t       phase;
  logic [DIST_W-1:0] acc;
  logic              acc_frozen;
  logic [CNT_W-1:0]  announced;
  logic [CNT_W-1:0]  done_pts;
  scan_rec_t         scan_results[$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_scan();
    spaces_seen = '0;
    phase       = PH_SEARCH;
    acc         = '0;
    acc_frozen  = 1'b0;
    announced   = '0;
    done_pts    = '0;
  endtask

  task automatic shift_digit(input logic [7:0] b);
    if (!acc_frozen) begin
      if (b >= 8'h30 && b <= 8'h39) begin
        acc = {acc[DIST_W-5:0], 4'(b - 8'h30)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
        acc = {acc[DIST_W-5:0], 4'(b - 8'h37)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
        acc = {acc[DIST_W-5:0], 4'(b - 8'h57)};
      end else begin
        acc_frozen = 1'b1;
      end
    end
  endtask

  task automatic parse_telegram_byte(input logic [7:0] b, input logic eob,
                                     output logic emitted, output scan_rec_t rec);
    emitted = 1'b0;
    rec     = '0;
    if (b == CH_ETX || eob) begin
      rec = '{kind: RK_SCAN_END, idx: '0, distance: '0, cnt: announced, last: 1'b1};
      emitted = 1'b1;
      clear_scan();
    end else begin
      case (phase)
        PH_SEARCH: begin
          if (b == CH_SPACE) begin
            if (spaces_seen != SPACE_SAT) spaces_seen++;
            if (spaces_seen == field_pos) begin
              phase      = PH_COUNT;
              acc        = '0;
              acc_frozen = 1'b0;
            end
          end
        end
        PH_COUNT: begin
          if (b == CH_SPACE) begin
            if (acc > MAX_POINTS) announced = CNT_W'(MAX_POINTS);
            else announced = CNT_W'(acc);
            acc        = '0;
            acc_frozen = 1'b0;
            done_pts   = '0;
            if (announced == 0) phase = PH_DONE;
            else phase = PH_DATA;
          end else begin
            shift_digit(b);
          end
        end
        PH_DATA: begin
          if (b == CH_SPACE || b == CH_NUL) begin
            rec = '{kind: RK_POINT, idx: done_pts[IDX_W-1:0], distance: acc, cnt: announced,
                    last: (int'(done_pts) + 1 >= int'(announced))};
            emitted = 1'b1;
            done_pts++;
            acc        = '0;
            acc_frozen = 1'b0;
            if (rec.last) phase = PH_DONE;
          end else begin
            shift_digit(b);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    scan_rec_t want;
    logic      emitted;
    if (!rst_n) begin
      field_pos = CFG_POS_RESET;
      clear_scan();
      scan_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) field_pos = cfg_data;
      if (out_valid && out_ready) begin
        if (scan_results.size() == 0) begin
          report_mismatch("result with none pending", out_result_kind, 0);
        end else begin
          want = scan_results.pop_front();
          if (out_result_kind !== want.kind)
            report_mismatch("result_kind", out_result_kind, want.kind);
          if (out_point_index !== want.idx)
            report_mismatch("point_index", out_point_index, want.idx);
          if (out_distance !== want.distance)
            report_mismatch("distance", out_distance, want.distance);
          if (out_point_count !== want.cnt)
            report_mismatch("point_count", out_point_count, want.cnt);
          if (out_is_last !== want.last)
            report_mismatch("is_last", out_is_last, want.last);
        end
      end
      if (in_valid && in_ready) begin
        parse_telegram_byte(in_rx_byte, in_end_of_buffer, emitted, want);
        if (emitted) scan_results.push_back(want);
      end
    end
    pending = scan_results.size();
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the ASCII hex scan telegram parser: clock, reset, telegram stimulus, verdict
module tb_top
  import ahst_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [POS_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = '0;
  logic              in_end_of_buffer = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_result_kind;
  logic [IDX_W-1:0]  out_point_index;
  logic [DIST_W-1:0] out_distance;
  logic [CNT_W-1:0]  out_point_count;
  logic              out_is_last;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       in_idle_pct = 0;
  int unsigned       out_idle_pct = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       quiet_cycles = 0;

  ascii_hex_scan_telegram_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_point_index  (out_point_index),
    .out_distance     (out_distance),
    .out_point_count  (out_point_count),
    .out_is_last      (out_is_last)
  );

  scan_result_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_point_index  (out_point_index),
    .out_distance     (out_distance),
    .out_point_count  (out_point_count),
    .out_is_last      (out_is_last),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE || b == CH_ETX);
    return b;
  endfunction

  // any byte that stops hex accumulation without ending the field
  function automatic logic [7:0] junk_byte(input bit allow_nul);
    logic [7:0] b;
    if (allow_nul && $urandom_range(0, 2) == 0) return CH_NUL;
    do b = 8'($urandom_range(0, 255));
    while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66) || b == CH_SPACE || b == CH_NUL || b == CH_ETX);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_byte       <= b;
    in_end_of_buffer <= eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [7:0] s[$], input bit eob_at_end);
    foreach (s[i]) send_byte(s[i], eob_at_end && (i == s.size() - 1));
  endtask

  // nd hex digits of v, mixed case, optionally with a junk byte spliced in
  task automatic send_hex(input logic [19:0] v, input int nd, input bit spoil,
                          input bit allow_nul);
    int         cut;
    logic [3:0] nib;
    cut = spoil ? $urandom_range(0, nd) : -1;
    for (int k = 0; k <= nd; k++) begin
      if (k == cut) send_byte(junk_byte(allow_nul), 1'b0);
      if (k < nd) begin
        nib = v[4*(nd-1-k) +: 4];
        if (nib < 10) send_byte(8'h30 + nib, 1'b0);
        else send_byte((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + nib - 8'd10, 1'b0);
      end
    end
  endtask

  task automatic drain_and_configure(input logic [POS_W-1:0] pos);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= pos;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_telegram(input logic [POS_W-1:0] pos, input bit full_scan);
    int          shape;
    int          n_sp;
    int          n_fields;
    int          nd;
    logic [19:0] count_val;
    shape = full_scan ? 9 : $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 40)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      n_sp = (pos == 0) ? $urandom_range(1, 70) : pos;
      if (shape == 1 && n_sp > 1 && $urandom_range(0, 1) != 0) n_sp--;
      for (int s = 0; s < n_sp; s++) begin
        repeat ($urandom_range(0, (n_sp > 20) ? 1 : 2)) send_byte(token_byte(), 1'b0);
        send_byte(CH_SPACE, 1'b0);
      end
      if (full_scan) begin
        count_val = 20'h0FFFF;
      end else begin
        case ($urandom_range(0, 15))
          0: count_val = 20'($urandom_range(1025, 20'hFFFFF));
          1: count_val = '0;
          default: count_val = 20'($urandom_range(1, 6));
        endcase
      end
      nd = 1;
      while (nd < 5 && (count_val >> (4 * nd)) != 0) nd++;
      if (nd < 5) nd += $urandom_range(0, 1);
      send_hex(count_val, nd, !full_scan && $urandom_range(0, 7) == 0, 1'b1);
      send_byte(CH_SPACE, 1'b0);
      n_fields = (count_val[15:0] > MAX_POINTS) ? MAX_POINTS : int'(count_val[15:0]);
      if (!full_scan && n_fields > 6) n_fields = $urandom_range(0, 4);
      else if (shape == 1) n_fields = $urandom_range(0, n_fields);
      else if (!full_scan) n_fields += $urandom_range(0, 2);
      for (int f = 0; f < n_fields; f++) begin
        nd = full_scan ? int'($urandom_range(0, 15) == 0) : $urandom_range(0, 5);
        send_hex(20'($urandom), nd, !full_scan && $urandom_range(0, 5) == 0, 1'b0);
        send_byte(($urandom_range(0, 3) == 0) ? CH_NUL : CH_SPACE, 1'b0);
      end
      // broken telegram: cut off inside a field
      if (shape == 1) send_hex(20'($urandom), $urandom_range(1, 3), 1'b0, 1'b0);
    end
    case ($urandom_range(0, 3))
      0, 1: send_byte(CH_ETX, 1'($urandom_range(0, 1)));
      2: send_byte(8'($urandom_range(0, 255)), 1'b1);
      default: send_byte(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_NUL, 1'b1);
    endcase
  endtask

  initial begin
    logic [7:0]       seq[$];
    logic [POS_W-1:0] pos;
    int unsigned      first;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    send_telegram(CFG_POS_RESET, 1'b0);
    drain_and_configure(6'd1);

    // count ended by NUL inside it, frozen field, empty last field, surplus, ETX
    seq = '{CH_SPACE, "3", CH_NUL, CH_SPACE, "f", "F", CH_SPACE, "A", "9", "z", "1",
            CH_NUL, CH_SPACE, "x", CH_ETX};
    send_string(seq, 1'b0);
    // zero count, then end of buffer on a high byte
    seq = '{CH_SPACE, "0", CH_SPACE, 8'hFF};
    send_string(seq, 1'b1);
    // five-digit count clipped to capacity, ETX inside a data field
    seq = '{CH_SPACE, "1", "2", "3", "4", "5", CH_SPACE, "5", CH_ETX};
    send_string(seq, 1'b1);
    // end of buffer on the terminator of a data field
    seq = '{CH_SPACE, "1", CH_SPACE, "7", CH_SPACE};
    send_string(seq, 1'b1);

    for (int m = 0; m < 3; m++) begin
      in_idle_pct  = (m == 0) ? 22 : (m == 1) ? 57 : 0;
      out_idle_pct = (m == 0) ? 57 : (m == 1) ? 22 : 0;
      for (int r = 0; r < 3; r++) begin
        case (3 * m + r)
          0: pos = 6'd63;
          1: pos = 6'd1;
          3: pos = 6'd0;
          4: pos = CFG_POS_RESET;
          6: pos = 6'd1;
          7: pos = 6'd63;
          default: pos = 6'($urandom_range(1, 8));
        endcase
        drain_and_configure(pos);
        first = bytes_sent;
        while (bytes_sent - first < 20) send_telegram(pos, 1'b0);
      end
    end
    // one full-capacity scan
    drain_and_configure(6'd1);
    send_telegram(6'd1, 1'b1);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
